FILE: hdl/mdc_pkg.sv
package mdc_pkg;

	// Geometry limits and window size
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int WINDOW     = 3;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(WINDOW * WINDOW + 1);
	localparam int FILL_W = (WINDOW > 2) ? $clog2(WINDOW - 1) : 1;

	localparam int WIN_AREA = WINDOW * WINDOW;
	localparam int WIN_HALF = (WINDOW * WINDOW) / 2;

	// Field and register widths
	localparam int PIX_W   = 8;
	localparam int TOTAL_W = 24;
	localparam int SIZE_W  = 11;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_CAP = 24'd9400356;

	// Register reset values
	localparam logic [PIX_W-1:0]   DIFF_THR_RST  = 8'd25;
	localparam logic [TOTAL_W-1:0] COUNT_THR_RST = 24'd5000;
	localparam logic [SIZE_W-1:0]  WIDTH_RST     = 11'd640;
	localparam logic [SIZE_W-1:0]  HEIGHT_RST    = 11'd360;

	// Reciprocal for (height-1) mod WINDOW
	localparam int HM_SHIFT = ROW_W + 3;
	localparam int HM_RECIP = ((2 ** HM_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int RECIP_W  = HM_SHIFT + 1;
	localparam int PROD_W   = ROW_W + RECIP_W;

	typedef enum logic [IDX_W-1:0] {
		CFG_DIFF_THR  = 2'd0,
		CFG_COUNT_THR = 2'd1,
		CFG_WIDTH     = 2'd2,
		CFG_HEIGHT    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_FILL = 2'b10
	} fill_state_t;

	// Link between neighboring window cells
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
	} link_t;

endpackage

FILE: hdl/mdc_ram.sv
module mdc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/mdc_cell.sv
module mdc_cell (
	input  logic          clk,
	input  logic          shift,
	input  mdc_pkg::link_t left,
	output mdc_pkg::link_t right
);

	// one column's mark count; takes the neighbor's column on each shift
	logic [mdc_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			cnt_q <= left.count;
		end
	end

	assign right.count = cnt_q;
	assign right.sum   = left.sum + mdc_pkg::SUM_W'(cnt_q);

endmodule

FILE: hdl/frame_difference_motion_count.sv
// Frame-difference motion counter. Pixel pairs (current/previous luma) enter
// in raster order at one transfer per clock; a pixel is marked when
// |cur - prev| >= diff_threshold. Marks go to WINDOW one-bit line RAMs of
// MAX_WIDTH entries each, all addressed by the current column, so one column
// of the window comes out per cycle and moves down a chain of WINDOW-1 cells.
// Each interior window with at least floor(WINDOW^2/2) marks adds WINDOW^2 to
// a saturating total. The last pixel of a frame yields one result transfer
// (total and total > count_threshold) through stage 1, stage 2 and the result
// register; the total then restarts. Sustained rate is one pixel per clock
// unless a second result meets a stalled output; a result register lets
// pixels keep flowing while one result waits. Input also stalls while the
// (height-1) mod WINDOW product settles after any register write, and when a
// width write leaves the column position past the new line end, while the
// fill state reloads the cell chain from the line RAMs. Line RAMs need no
// clearing pass after reset.
module frame_difference_motion_count (
	input  logic                         clk,
	input  logic                         arst_n,
	// register write port
	input  logic                         cfg_we,
	input  logic [mdc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [mdc_pkg::CFG_W-1:0]    cfg_data,
	// pixel channel
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  logic [mdc_pkg::PIX_W-1:0]    cur_pixel,
	input  logic [mdc_pkg::PIX_W-1:0]    prev_pixel,
	// result channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [mdc_pkg::TOTAL_W-1:0]  motion_count,
	output logic                         motion_detected
);

	localparam int W = mdc_pkg::WINDOW;

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	logic [mdc_pkg::PIX_W-1:0]   diff_thr_q;
	logic [mdc_pkg::TOTAL_W-1:0] count_thr_q;
	logic [mdc_pkg::SIZE_W-1:0]  frame_width_q;
	logic [mdc_pkg::SIZE_W-1:0]  frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_thr_q     <= mdc_pkg::DIFF_THR_RST;
			count_thr_q    <= mdc_pkg::COUNT_THR_RST;
			frame_width_q  <= mdc_pkg::WIDTH_RST;
			frame_height_q <= mdc_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (mdc_pkg::cfg_reg_t'(cfg_index))
				mdc_pkg::CFG_DIFF_THR:  diff_thr_q     <= cfg_data[mdc_pkg::PIX_W-1:0];
				mdc_pkg::CFG_COUNT_THR: count_thr_q    <= cfg_data[mdc_pkg::TOTAL_W-1:0];
				mdc_pkg::CFG_WIDTH:     frame_width_q  <= cfg_data[mdc_pkg::SIZE_W-1:0];
				mdc_pkg::CFG_HEIGHT:    frame_height_q <= cfg_data[mdc_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective last column / last line: zero acts as one, oversize as max.
	logic [mdc_pkg::COL_W-1:0] wm1;
	logic [mdc_pkg::ROW_W-1:0] hm1;

	always_comb begin
		if (frame_width_q == '0) begin
			wm1 = '0;
		end else if (32'(frame_width_q) > 32'(mdc_pkg::MAX_WIDTH)) begin
			wm1 = mdc_pkg::COL_W'(mdc_pkg::MAX_WIDTH - 1);
		end else begin
			wm1 = mdc_pkg::COL_W'(frame_width_q - 11'd1);
		end
		if (frame_height_q == '0) begin
			hm1 = '0;
		end else if (32'(frame_height_q) > 32'(mdc_pkg::MAX_HEIGHT)) begin
			hm1 = mdc_pkg::ROW_W'(mdc_pkg::MAX_HEIGHT - 1);
		end else begin
			hm1 = mdc_pkg::ROW_W'(frame_height_q - 11'd1);
		end
	end

	// Line slot of the last line, (hm1 mod WINDOW), via reciprocal multiply.
	// Two register levels; input is held off while it settles after a write.
	logic [mdc_pkg::PROD_W-1:0]  hm_prod_q;
	logic [mdc_pkg::ROW_W-1:0]   hm1_q;
	logic [mdc_pkg::ROW_W-1:0]   hm_quot;
	logic [mdc_pkg::ROW_W-1:0]   hm_rem;
	logic [mdc_pkg::SLOT_W-1:0]  hslot_q;

	always_ff @(posedge clk) begin
		hm_prod_q <= mdc_pkg::PROD_W'(hm1) * mdc_pkg::PROD_W'(mdc_pkg::HM_RECIP);
		hm1_q     <= hm1;
		hslot_q   <= (32'(hm_rem) >= W) ? mdc_pkg::SLOT_W'(hm_rem - mdc_pkg::ROW_W'(W))
		                                : mdc_pkg::SLOT_W'(hm_rem);
	end

	assign hm_quot = hm_prod_q[mdc_pkg::HM_SHIFT +: mdc_pkg::ROW_W];
	assign hm_rem  = mdc_pkg::ROW_W'(hm1_q - mdc_pkg::ROW_W'(hm_quot * mdc_pkg::ROW_W'(W)));

	logic [1:0] settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd2;
		end else if (cfg_we) begin
			settle_q <= 2'd2;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// ---------------------------------------------------------------
	// Raster position (stage 0)
	// ---------------------------------------------------------------
	logic [mdc_pkg::COL_W-1:0]  col_q;
	logic [mdc_pkg::ROW_W-1:0]  row_q;
	logic [mdc_pkg::SLOT_W-1:0] slot_q;

	logic                       col_over, row_over;
	logic [mdc_pkg::COL_W-1:0]  col_eff;
	logic [mdc_pkg::ROW_W-1:0]  row_eff;
	logic [mdc_pkg::SLOT_W-1:0] slot_eff;
	logic                       col_last, row_last, frame_last, judge;
	logic [mdc_pkg::PIX_W-1:0]  diff;
	logic                       mark;

	// a position already past a shrunk frame is taken as the last column/line
	assign col_over   = col_q > wm1;
	assign row_over   = row_q > hm1;
	assign col_eff    = col_over ? wm1 : col_q;
	assign row_eff    = row_over ? hm1 : row_q;
	assign slot_eff   = row_over ? hslot_q : slot_q;
	assign col_last   = col_eff == wm1;
	assign row_last   = row_eff == hm1;
	assign frame_last = col_last && row_last;
	assign judge      = (32'(col_eff) >= W - 1) && (32'(row_eff) >= W - 1);

	assign diff = (cur_pixel >= prev_pixel) ? (cur_pixel - prev_pixel)
	                                        : (prev_pixel - cur_pixel);
	assign mark = diff >= diff_thr_q;

	// ---------------------------------------------------------------
	// Flow control
	// ---------------------------------------------------------------
	logic hold;          // result stage blocked by a full, stalled output
	logic need_fill;     // column jumped back: reload the cell chain
	logic fill_rd;       // reload read this cycle
	logic pix_accept;

	mdc_pkg::fill_state_t     state_q, state_d;
	logic [mdc_pkg::FILL_W-1:0] fill_cnt_q, fill_cnt_d;
	logic                       fill_done_q, fill_done_d;

	assign need_fill  = col_over && !fill_done_q;
	assign pix_stall  = hold || (settle_q != 2'd0) || need_fill || (state_q == mdc_pkg::ST_FILL);
	assign pix_accept = pix_valid && !pix_stall;
	assign fill_rd    = (state_q == mdc_pkg::ST_FILL) && !hold;

	always_comb begin
		state_d     = state_q;
		fill_cnt_d  = fill_cnt_q;
		fill_done_d = fill_done_q;
		if (cfg_we) begin
			state_d     = mdc_pkg::ST_RUN;
			fill_done_d = 1'b0;
		end else begin
			unique case (state_q)
				mdc_pkg::ST_RUN: begin
					if (pix_accept) begin
						fill_done_d = 1'b0;
					end
					if (need_fill && settle_q == 2'd0 && !hold) begin
						state_d    = mdc_pkg::ST_FILL;
						fill_cnt_d = '0;
					end
				end
				mdc_pkg::ST_FILL: begin
					if (!hold) begin
						if (32'(fill_cnt_q) == W - 2) begin
							state_d     = mdc_pkg::ST_RUN;
							fill_done_d = 1'b1;
						end else begin
							fill_cnt_d = fill_cnt_q + 1'b1;
						end
					end
				end
				default: state_d = mdc_pkg::ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mdc_pkg::ST_RUN;
			fill_cnt_q  <= '0;
			fill_done_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_cnt_q  <= fill_cnt_d;
			fill_done_q <= fill_done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (pix_accept) begin
			if (frame_last) begin
				col_q  <= '0;
				row_q  <= '0;
				slot_q <= '0;
			end else if (col_last) begin
				col_q  <= '0;
				row_q  <= row_eff + 1'b1;
				slot_q <= (32'(slot_eff) == W - 1) ? '0 : slot_eff + 1'b1;
			end else begin
				col_q  <= col_eff + 1'b1;
				row_q  <= row_eff;
				slot_q <= slot_eff;
			end
		end
	end

	// ---------------------------------------------------------------
	// Line RAMs: one per line slot, write and read at the same column.
	// The slot being written is bypassed with the fresh mark in stage 1.
	// ---------------------------------------------------------------
	logic [mdc_pkg::COL_W-1:0] fill_addr;
	logic [mdc_pkg::COL_W-1:0] rd_addr;
	logic [W-1:0]              line_rd;

	assign fill_addr = wm1 - mdc_pkg::COL_W'(W - 1) + mdc_pkg::COL_W'(fill_cnt_q);
	assign rd_addr   = fill_rd ? fill_addr : col_eff;

	for (genvar k = 0; k < W; k++) begin : g_line
		mdc_ram #(
			.WIDTH(1),
			.DEPTH(mdc_pkg::MAX_WIDTH)
		) u_line (
			.clk  (clk),
			.we   (pix_accept && (32'(slot_eff) == k)),
			.waddr(col_eff),
			.wdata(mark),
			.re   (pix_accept || fill_rd),
			.raddr(rd_addr),
			.rdata(line_rd[k])
		);
	end

	// ---------------------------------------------------------------
	// Stage 1: column count, cell chain, running total
	// ---------------------------------------------------------------
	logic                       valid_s1, fill_s1, mark_s1, judge_s1, last_s1;
	logic [mdc_pkg::SLOT_W-1:0] slot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= pix_accept || fill_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			fill_s1  <= fill_rd;
			mark_s1  <= mark;
			judge_s1 <= judge;
			last_s1  <= frame_last;
			slot_s1  <= slot_eff;
		end
	end

	logic [W-1:0]             col_bits;
	logic [mdc_pkg::CNT_W-1:0] col_count;
	logic                      advance_s1;

	always_comb begin
		col_count = '0;
		for (int k = 0; k < W; k++) begin
			col_bits[k] = (!fill_s1 && (32'(slot_s1) == k)) ? mark_s1 : line_rd[k];
			col_count   = col_count + mdc_pkg::CNT_W'(col_bits[k]);
		end
	end

	assign advance_s1 = valid_s1 && !hold;

	// newest column enters at link 0; each cell adds one older column
	mdc_pkg::link_t links [W];

	assign links[0].count = col_count;
	assign links[0].sum   = mdc_pkg::SUM_W'(col_count);

	for (genvar k = 0; k < W - 1; k++) begin : g_cell
		mdc_cell u_cell (
			.clk  (clk),
			.shift(advance_s1),
			.left (links[k]),
			.right(links[k+1])
		);
	end

	logic                        qualify;
	logic [mdc_pkg::TOTAL_W-1:0] total_q, total_next;

	assign qualify = judge_s1 && !fill_s1 &&
	                 (32'(links[W-1].sum) >= mdc_pkg::WIN_HALF);

	always_comb begin
		total_next = total_q;
		if (qualify) begin
			if (total_q > mdc_pkg::TOTAL_CAP - mdc_pkg::TOTAL_W'(mdc_pkg::WIN_AREA)) begin
				total_next = mdc_pkg::TOTAL_CAP;
			end else begin
				total_next = total_q + mdc_pkg::TOTAL_W'(mdc_pkg::WIN_AREA);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (advance_s1 && !fill_s1) begin
			total_q <= last_s1 ? '0 : total_next;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: frame total, then result register
	// ---------------------------------------------------------------
	logic                        res_valid_s2;
	logic [mdc_pkg::TOTAL_W-1:0] res_total_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (!hold) begin
			res_valid_s2 <= valid_s1 && !fill_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			res_total_s2 <= total_next;
		end
	end

	logic                        out_valid_q;
	logic [mdc_pkg::TOTAL_W-1:0] motion_count_q;
	logic                        motion_detected_q;
	logic                        out_load;

	assign hold     = res_valid_s2 && out_valid_q && res_stall;
	assign out_load = res_valid_s2 && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			motion_count_q    <= res_total_s2;
			motion_detected_q <= res_total_s2 > count_thr_q;
		end
	end

	assign res_valid       = out_valid_q;
	assign motion_count    = motion_count_q;
	assign motion_detected = motion_detected_q;

endmodule

FILE: dv/tb_frame_difference_motion_count.sv
module tb_frame_difference_motion_count;
	timeunit 1ns;
	timeprecision 1ps;

	// Idle margin after the last expected result has come out; leave some
	// margin before touching the registers or ending the run.
	localparam int SETTLE_CYCLES      = 8;
	// Cycles without any transfer before the run is declared hung
	localparam int WATCHDOG_LIMIT     = 2000;
	localparam int MIN_RANDOM_PIXELS  = 560;
	localparam int MIN_RANDOM_FRAMES  = 16;
	localparam int MAX_REPORTS        = 10;

	typedef struct packed {
		logic [mdc_pkg::TOTAL_W-1:0] count;
		logic                        detected;
	} frame_result_t;

	logic                        clk             = 1'b0;
	logic                        arst_n          = 1'b0;
	logic                        cfg_we          = 1'b0;
	logic [mdc_pkg::IDX_W-1:0]   cfg_index       = '0;
	logic [mdc_pkg::CFG_W-1:0]   cfg_data        = '0;
	logic                        pix_valid       = 1'b0;
	logic                        pix_stall;
	logic [mdc_pkg::PIX_W-1:0]   cur_pixel       = '0;
	logic [mdc_pkg::PIX_W-1:0]   prev_pixel      = '0;
	logic                        res_valid;
	logic                        res_stall       = 1'b0;
	logic [mdc_pkg::TOTAL_W-1:0] motion_count;
	logic                        motion_detected;

	frame_difference_motion_count dut (.*);

	always #1 clk = ~clk;

	// Idling knobs, percent of cycles
	int pix_gap_pct   = 0;
	int res_stall_pct = 0;

	int fail_count  = 0;
	int idle_cycles = 0;

	// Register shadow, tracks what the block holds
	logic [mdc_pkg::PIX_W-1:0]   diff_thr  = mdc_pkg::DIFF_THR_RST;
	logic [mdc_pkg::TOTAL_W-1:0] count_thr = mdc_pkg::COUNT_THR_RST;
	logic [mdc_pkg::SIZE_W-1:0]  frame_w   = mdc_pkg::WIDTH_RST;
	logic [mdc_pkg::SIZE_W-1:0]  frame_h   = mdc_pkg::HEIGHT_RST;

	// Predictor state: change marks per line slot, raster position, weighted total
	logic mark_rows [mdc_pkg::WINDOW][mdc_pkg::MAX_WIDTH];
	int   col_pos   = 0;
	int   row_pos   = 0;
	int   run_total = 0;

	// Frame totals predicted but not yet seen on the result channel
	frame_result_t pending_totals[$];

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("%s", msg);
		end
	endfunction

	// Size register as the block sees it: zero acts as one, too big acts as max
	function automatic int eff_size(input logic [mdc_pkg::SIZE_W-1:0] v, input int limit);
		if (v == 0) begin
			return 1;
		end
		if (v > limit) begin
			return limit;
		end
		return int'(v);
	endfunction

	// Advance the predictor by one accepted pixel; queue the frame result at
	// the last pixel.
	task automatic predict_pixel(input logic [mdc_pkg::PIX_W-1:0] cur,
			input logic [mdc_pkg::PIX_W-1:0] prev);
		int w;
		int h;
		int c;
		int r;
		int delta;
		int marks;
		frame_result_t res;
		w = eff_size(frame_w, mdc_pkg::MAX_WIDTH);
		h = eff_size(frame_h, mdc_pkg::MAX_HEIGHT);
		// a position left past a shrunk frame counts as the last column / line
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		delta = int'(cur) - int'(prev);
		if (delta < 0) begin
			delta = -delta;
		end
		mark_rows[r % mdc_pkg::WINDOW][c] = (delta >= diff_thr);
		// the pixel closes the window whose bottom-right corner it is
		if (c >= mdc_pkg::WINDOW - 1 && r >= mdc_pkg::WINDOW - 1) begin
			marks = 0;
			for (int rr = r - (mdc_pkg::WINDOW - 1); rr <= r; rr++) begin
				for (int cc = c - (mdc_pkg::WINDOW - 1); cc <= c; cc++) begin
					marks += mark_rows[rr % mdc_pkg::WINDOW][cc];
				end
			end
			if (marks >= mdc_pkg::WIN_HALF) begin
				if (run_total + mdc_pkg::WIN_AREA > mdc_pkg::TOTAL_CAP) begin
					run_total = int'(mdc_pkg::TOTAL_CAP);
				end else begin
					run_total += mdc_pkg::WIN_AREA;
				end
			end
		end
		if (c == w - 1 && r == h - 1) begin
			res.count    = run_total[mdc_pkg::TOTAL_W-1:0];
			res.detected = (run_total > count_thr);
			pending_totals.push_back(res);
			run_total = 0;
			col_pos   = 0;
			row_pos   = 0;
		end else if (c == w - 1) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// One pixel transfer. Random idle cycles go in front; once valid is up
	// it stays up with the payload held until the block takes it.
	task automatic send_pixel(input logic [mdc_pkg::PIX_W-1:0] cur,
			input logic [mdc_pkg::PIX_W-1:0] prev);
		while ($urandom_range(99, 0) < pix_gap_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid  <= 1'b1;
		cur_pixel  <= cur;
		prev_pixel <= prev;
		@(posedge clk);
		while (pix_stall) begin
			@(posedge clk);
		end
		predict_pixel(cur, prev);
	endtask

	// Pixel pair that lands on the requested side of the change threshold,
	// half the time right at the boundary.
	task automatic send_change(input bit marked);
		int delta;
		int base;
		if (diff_thr == 0) begin
			marked = 1'b1;
		end
		if (marked) begin
			delta = $urandom_range(1, 0) ? int'(diff_thr) : $urandom_range(255, diff_thr);
		end else begin
			delta = $urandom_range(1, 0) ? int'(diff_thr) - 1 : $urandom_range(diff_thr - 1, 0);
		end
		base = $urandom_range(255 - delta, 0);
		if ($urandom_range(1, 0)) begin
			send_pixel(mdc_pkg::PIX_W'(base + delta), mdc_pkg::PIX_W'(base));
		end else begin
			send_pixel(mdc_pkg::PIX_W'(base), mdc_pkg::PIX_W'(base + delta));
		end
	endtask

	// A whole frame at the current size, starting from the top-left pixel
	task automatic send_frame(input int mark_pct);
		int pixels;
		pixels = eff_size(frame_w, mdc_pkg::MAX_WIDTH) * eff_size(frame_h, mdc_pkg::MAX_HEIGHT);
		repeat (pixels) begin
			send_change($urandom_range(99, 0) < mark_pct);
		end
	endtask

	// Drop valid, let every predicted result come out, then give the
	// pipeline time to finish whatever it holds.
	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (pending_totals.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input mdc_pkg::cfg_reg_t idx, input int data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= mdc_pkg::CFG_W'(data);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mdc_pkg::CFG_DIFF_THR: begin
				diff_thr = mdc_pkg::PIX_W'(data);
			end
			mdc_pkg::CFG_COUNT_THR: begin
				count_thr = mdc_pkg::TOTAL_W'(data);
			end
			mdc_pkg::CFG_WIDTH: begin
				frame_w = mdc_pkg::SIZE_W'(data);
			end
			mdc_pkg::CFG_HEIGHT: begin
				frame_h = mdc_pkg::SIZE_W'(data);
			end
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input int diff, input int count, input int w, input int h);
		wait_idle();
		write_reg(mdc_pkg::CFG_DIFF_THR, diff);
		write_reg(mdc_pkg::CFG_COUNT_THR, count);
		write_reg(mdc_pkg::CFG_WIDTH, w);
		write_reg(mdc_pkg::CFG_HEIGHT, h);
	endtask

	// Smallest frame with one window: zero threshold marks every pixel, the
	// top threshold marks only full-scale pairs, and the window passes at
	// half its area rounded down but not one below. Also total equal to and above
	// the count threshold.
	task automatic test_thresholds();
		logic [2*mdc_pkg::PIX_W-1:0] all_marked [9] = '{16'h0000, 16'hFFFF, 16'h00FF,
			16'hFF00, 16'h55AA, 16'hAA55, 16'h0100, 16'h807F, 16'h7F80};
		logic [2*mdc_pkg::PIX_W-1:0] four_marks [9] = '{16'hFF00, 16'h00FF, 16'hFF00,
			16'h00FF, 16'hFE00, 16'h00FE, 16'hFF01, 16'h01FF, 16'h8080};
		logic [2*mdc_pkg::PIX_W-1:0] three_marks [9] = '{16'hFF00, 16'h00FF, 16'hFF00,
			16'hFEFF, 16'h0000, 16'hFFFF, 16'h7F80, 16'h01FF, 16'hFE00};
		pix_gap_pct   = 0;
		res_stall_pct = 0;
		configure(0, 8, 3, 3);
		foreach (all_marked[i]) begin
			send_pixel(all_marked[i][15:8], all_marked[i][7:0]);
		end
		configure(255, 9, 3, 3);
		foreach (four_marks[i]) begin
			send_pixel(four_marks[i][15:8], four_marks[i][7:0]);
		end
		configure(255, 0, 3, 3);
		foreach (three_marks[i]) begin
			send_pixel(three_marks[i][15:8], three_marks[i][7:0]);
		end
	endtask

	// Out-of-range sizes: zero acts as one and oversize acts as the maximum;
	// frames thinner than the window never count anything.
	task automatic test_size_clamp();
		pix_gap_pct   = 56;
		res_stall_pct = 0;
		configure(30, 0, 0, 6);
		send_frame(50);
		configure(30, 0, 6, 0);
		send_frame(50);
		configure(30, 0, 2, 5);
		send_frame(80);
		configure(30, 0, 5, 2);
		send_frame(80);
		configure(30, 0, 1, 1);
		send_frame(80);
		send_frame(80);
		// oversize on both axes, then shrink to 3x3 while still on line 0
		configure(30, 0, 2047, 2047);
		repeat (5) begin
			send_change($urandom_range(99, 0) < 80);
		end
		wait_idle();
		write_reg(mdc_pkg::CFG_WIDTH, 3);
		write_reg(mdc_pkg::CFG_HEIGHT, 3);
		// column 5 closes line 0 as column 2, then lines 1 and 2
		repeat (7) begin
			send_change($urandom_range(99, 0) < 80);
		end
	endtask

	// Shrinking the frame while inside it. Only shrinks: every mark the
	// windows then read was written earlier in the same frame.
	task automatic test_midframe_resize();
		pix_gap_pct   = 0;
		res_stall_pct = 56;
		configure(40, 20, 8, 6);
		// lines 0 and 1, then line 2 up to column 5
		repeat (22) begin
			send_change($urandom_range(99, 0) < 60);
		end
		wait_idle();
		// column 6 is now past the end: next pixel closes line 2 as column 3
		write_reg(mdc_pkg::CFG_WIDTH, 4);
		repeat (7) begin
			send_change($urandom_range(99, 0) < 60);
		end
		wait_idle();
		// sitting in line 4 of 3: it becomes the last line of the frame
		write_reg(mdc_pkg::CFG_HEIGHT, 3);
		repeat (2) begin
			send_change($urandom_range(99, 0) < 60);
		end
	endtask

	// Mostly small frames back to back, with new settings now and then.
	// Idling mode rotates every four frames.
	task automatic test_random_frames();
		int pixels;
		int frames;
		int w;
		int h;
		int diff;
		int count;
		pixels = 0;
		frames = 0;
		while (pixels < MIN_RANDOM_PIXELS || frames < MIN_RANDOM_FRAMES) begin
			case ((frames / 4) % 4)
				0: begin
					pix_gap_pct   = 0;
					res_stall_pct = 0;
				end
				1: begin
					pix_gap_pct   = 56;
					res_stall_pct = 0;
				end
				2: begin
					pix_gap_pct   = 0;
					res_stall_pct = 56;
				end
				default: begin
					pix_gap_pct   = 6;
					res_stall_pct = 6;
				end
			endcase
			if (frames == 0 || $urandom_range(2, 0) == 0) begin
				case ($urandom_range(9, 0))
					0: begin
						w = $urandom_range(2, 0);
						h = $urandom_range(8, 0);
					end
					1: begin
						w = $urandom_range(10, 0);
						h = $urandom_range(2, 0);
					end
					2: begin
						w = $urandom_range(40, 3);
						h = $urandom_range(12, 3);
					end
					default: begin
						w = $urandom_range(10, 3);
						h = $urandom_range(8, 3);
					end
				endcase
				case ($urandom_range(9, 0))
					0: diff = 0;
					1: diff = 255;
					default: diff = $urandom_range(254, 1);
				endcase
				case ($urandom_range(9, 0))
					0: count = 0;
					1: count = 24'hFFFFFF;
					2: count = int'(mdc_pkg::TOTAL_CAP);
					default: count = $urandom_range(w * h * mdc_pkg::WIN_AREA, 0);
				endcase
				configure(diff, count, w, h);
			end
			send_frame($urandom_range(100, 0));
			pixels += eff_size(frame_w, mdc_pkg::MAX_WIDTH) *
			          eff_size(frame_h, mdc_pkg::MAX_HEIGHT);
			frames++;
		end
	endtask

	// Result side back-pressure
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99, 0) < res_stall_pct);
	end

	// Compare each result transfer against the oldest predicted frame
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_totals.size() == 0) begin
				note_failure($sformatf("unexpected result: count %0d detected %0b",
					motion_count, motion_detected));
			end else begin
				want = pending_totals.pop_front();
				if (motion_count !== want.count) begin
					note_failure($sformatf("motion_count mismatch: expected %0d got %0d",
						want.count, motion_count));
				end
				if (motion_detected !== want.detected) begin
					note_failure($sformatf("motion_detected mismatch: expected %0b got %0b",
						want.detected, motion_detected));
				end
			end
		end
	end

	// Hang detection: any transfer on either channel clears the count
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("hung: no transfer for %0d cycles", idle_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (11) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);
		test_thresholds();
		test_size_clamp();
		test_midframe_resize();
		test_random_frames();
		wait_idle();
		if (fail_count == 0 && pending_totals.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: frame_difference_motion_count.f
hdl/mdc_pkg.sv
hdl/mdc_ram.sv
hdl/mdc_cell.sv
hdl/frame_difference_motion_count.sv
dv/tb_frame_difference_motion_count.sv
